// ----- src/sfe_pkg.sv -----
// ----------------------------------------------------------------------------
// sfe_pkg
// Shared constants and word types for the stereo feedback echo.
// ----------------------------------------------------------------------------
package sfe_pkg;

	localparam int RING_LENGTH = 22050;
	localparam int PTR_W       = $clog2(RING_LENGTH);

	localparam int SAMPLE_W    = 20;
	localparam int STORE_W     = 16;
	localparam int ENTRY_W     = 2 * STORE_W;
	localparam int DELAY_W     = 15;
	localparam int GAIN_W      = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	// reciprocal for delay mod ring length: q_est = (d * RECIP) >> DELAY_W
	localparam int RECIP       = (1 << DELAY_W) / RING_LENGTH;

	localparam int OQ_DEPTH    = 4;
	localparam int OQ_PTR_W    = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W    = $clog2(OQ_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_ECHO_ENABLE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_SAMPLES = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ECHO_GAIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 3'd3;

	localparam logic signed [SAMPLE_W:0]  SUM_MIN   = -21'sd32768;
	localparam logic signed [SAMPLE_W:0]  SUM_MAX   = 21'sd32767;
	localparam logic signed [STORE_W-1:0] STORE_MIN = -16'sd32768;
	localparam logic signed [STORE_W-1:0] STORE_MAX = 16'sd32767;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_in;
		logic signed [SAMPLE_W-1:0] right_in;
		logic                       block_end;
	} frame_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_out;
		logic signed [SAMPLE_W-1:0] right_out;
		logic                       block_end_out;
	} echo_t;

endpackage

// ----- src/sfe_ram.sv -----
// ----------------------------------------------------------------------------
// sfe_ram
// Simple dual-port RAM, one write port, one read port, registered read data.
// Read during write to the same address returns the old contents.
// ----------------------------------------------------------------------------
module sfe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/sfe_out_fifo.sv -----
// ----------------------------------------------------------------------------
// sfe_out_fifo
// Small result queue between the echo pipeline and the output channel.
// Space is reserved by the producer before a frame enters the pipeline.
// ----------------------------------------------------------------------------
module sfe_out_fifo
	import sfe_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  echo_t               push_word,
	output logic                word_valid,
	input  logic                word_stall,
	output echo_t               word,
	output logic [OQ_CNT_W-1:0] count
);

	echo_t               slot_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wr_ptr_q;
	logic [OQ_PTR_W-1:0] rd_ptr_q;
	logic [OQ_CNT_W-1:0] count_q;
	logic                pop;

	assign word_valid = (count_q != '0);
	assign word       = slot_q[rd_ptr_q];
	assign pop        = word_valid && !word_stall;
	assign count      = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

// ----- src/stereo_feedback_echo.sv -----
// ----------------------------------------------------------------------------
// Path: an accepted frame is registered into stage 1, then stage 2, then the result queue, before its echo word shows.
// Throughput: one frame per cycle unless frame_stall is raised (config busy, queue
// full, or a delay of one frame (mod ring length) waiting for the previous write-back).
// Writing delay_samples holds the config and frame ports while the new delay is reduced (mod_a_q, then mod_b_q).
// Reset: config and valid registers, write pointer and wrap flag cleared; unwritten ring entries
// read as zero through the wrap flag, so there is no clearing pass.
// ----------------------------------------------------------------------------
// stereo_feedback_echo
// Stereo feedback echo over a ring memory: read, scale, mix, saturate and
// write back, with one forwarding register and a one-entry interlock.
// ----------------------------------------------------------------------------
module stereo_feedback_echo
	import sfe_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  frame_valid,
	output logic                  frame_stall,
	input  frame_t                frame,
	output logic                  echo_valid,
	input  logic                  echo_stall,
	output echo_t                 echo,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	function automatic logic signed [17:0] scale_q14(input logic signed [31:0] p);
		logic signed [31:0] biased;
		biased = p + (p[31] ? 32'sd16383 : 32'sd0);
		return signed'(biased[31:14]);
	endfunction

	function automatic logic signed [STORE_W-1:0] sat16(input logic signed [SAMPLE_W:0] v);
		logic signed [STORE_W-1:0] r;
		if (v < SUM_MIN) begin
			r = STORE_MIN;
		end else if (v > SUM_MAX) begin
			r = STORE_MAX;
		end else begin
			r = v[STORE_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [SAMPLE_W:0] mix(input logic signed [SAMPLE_W-1:0] s,
		input logic signed [17:0] e);
		return signed'({s[SAMPLE_W-1], s} + {{(SAMPLE_W-17){e[17]}}, e});
	endfunction

	// configuration
	logic                     enable_q;
	logic [PTR_W-1:0]         delay_q;
	logic signed [GAIN_W-1:0] eg_q;
	logic signed [GAIN_W-1:0] fg_q;
	logic [DELAY_W-1:0]       delay_raw_q;
	logic [DELAY_W-1:0]       quo_q;
	logic                     mod_a_q;
	logic                     mod_b_q;
	logic                     cfg_we;
	logic [2*DELAY_W-1:0]     recip_prod;
	logic [DELAY_W+1:0]       quo_mul;
	logic [DELAY_W+1:0]       rem;
	logic [DELAY_W+1:0]       rem_fix;

	// pointer and read address
	logic [PTR_W-1:0]         wp_q;
	logic                     wrapped_q;
	logic [PTR_W:0]           rp_wide;
	logic [PTR_W-1:0]         rp;
	logic                     hazard;
	logic                     accept;
	logic [OQ_CNT_W:0]        occ;
	logic [OQ_CNT_W-1:0]      oq_count;

	// stage 1
	logic                     v_s1;
	logic                     wr_s1;
	logic [PTR_W-1:0]         wp_s1;
	logic                     fwd_hit_s1;
	logic [ENTRY_W-1:0]       fwd_data_s1;
	logic                     zero_s1;
	frame_t                   frame_s1;
	logic [ENTRY_W-1:0]       ram_rdata;
	logic [ENTRY_W-1:0]       dly_word;
	logic signed [15:0]       dly_l;
	logic signed [15:0]       dly_r;
	logic signed [31:0]       pe_l;
	logic signed [31:0]       pe_r;
	logic signed [31:0]       pf_l;
	logic signed [31:0]       pf_r;

	// stage 2
	logic                     v_s2;
	logic                     wr_s2;
	logic [PTR_W-1:0]         wp_s2;
	frame_t                   frame_s2;
	logic signed [31:0]       pe_l_s2;
	logic signed [31:0]       pe_r_s2;
	logic signed [31:0]       pf_l_s2;
	logic signed [31:0]       pf_r_s2;
	logic signed [STORE_W-1:0] out_l;
	logic signed [STORE_W-1:0] out_r;
	logic signed [STORE_W-1:0] st_l;
	logic signed [STORE_W-1:0] st_r;
	logic [ENTRY_W-1:0]       store_word;
	echo_t                    result;

	// delay mod ring length: multiply by reciprocal, then one correction
	assign recip_prod = delay_raw_q * DELAY_W'(RECIP);
	assign quo_mul    = (DELAY_W+2)'(quo_q) * (DELAY_W+2)'(RING_LENGTH);
	assign rem        = {2'b00, delay_raw_q} - quo_mul;
	assign rem_fix    = (rem >= (DELAY_W+2)'(RING_LENGTH)) ?
		rem - (DELAY_W+2)'(RING_LENGTH) : rem;

	assign cfg_ready = !(mod_a_q || mod_b_q);
	assign cfg_we    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			delay_q  <= '0;
			eg_q     <= '0;
			fg_q     <= '0;
			mod_a_q  <= 1'b0;
			mod_b_q  <= 1'b0;
		end else begin
			mod_a_q <= cfg_we && (cfg_index == CFG_DELAY_SAMPLES);
			mod_b_q <= mod_a_q;
			if (mod_b_q) begin
				delay_q <= rem_fix[PTR_W-1:0];
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_ECHO_ENABLE:   enable_q <= cfg_data[0];
					CFG_ECHO_GAIN:     eg_q     <= signed'(cfg_data);
					CFG_FEEDBACK_GAIN: fg_q     <= signed'(cfg_data);
					default:           ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cfg_we && cfg_index == CFG_DELAY_SAMPLES) begin
			delay_raw_q <= cfg_data[DELAY_W-1:0];
		end
		if (mod_a_q) begin
			quo_q <= recip_prod[2*DELAY_W-1:DELAY_W];
		end
	end

	// read address and admission
	assign rp_wide = {1'b0, wp_q} - {1'b0, delay_q} +
		((wp_q >= delay_q) ? '0 : (PTR_W+1)'(RING_LENGTH));
	assign rp      = rp_wide[PTR_W-1:0];
	assign hazard  = enable_q && v_s1 && wr_s1 && (wp_s1 == rp);
	assign occ     = (OQ_CNT_W+1)'(oq_count) + (OQ_CNT_W+1)'(v_s1) + (OQ_CNT_W+1)'(v_s2);

	assign frame_stall = !cfg_ready || hazard || (occ >= (OQ_CNT_W+1)'(OQ_DEPTH));
	assign accept      = frame_valid && !frame_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			if (accept && enable_q) begin
				if (wp_q == PTR_W'(RING_LENGTH - 1)) begin
					wp_q      <= '0;
					wrapped_q <= 1'b1;
				end else begin
					wp_q <= wp_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			frame_s1    <= frame;
			wr_s1       <= enable_q;
			wp_s1       <= wp_q;
			fwd_hit_s1  <= v_s2 && wr_s2 && (wp_s2 == rp);
			fwd_data_s1 <= store_word;
			zero_s1     <= !(wrapped_q || (rp < wp_q));
		end
		if (v_s1) begin
			frame_s2 <= frame_s1;
			wr_s2    <= wr_s1;
			wp_s2    <= wp_s1;
			pe_l_s2  <= pe_l;
			pe_r_s2  <= pe_r;
			pf_l_s2  <= pf_l;
			pf_r_s2  <= pf_r;
		end
	end

	sfe_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (RING_LENGTH)
	) u_ring (
		.clk   (clk),
		.we    (v_s2 && wr_s2),
		.waddr (wp_s2),
		.wdata (store_word),
		.re    (accept),
		.raddr (rp),
		.rdata (ram_rdata)
	);

	// stage 1: pick delayed entry, scale by both gains
	always_comb begin
		if (fwd_hit_s1) begin
			dly_word = fwd_data_s1;
		end else if (zero_s1) begin
			dly_word = '0;
		end else begin
			dly_word = ram_rdata;
		end
		dly_l = signed'(dly_word[STORE_W-1:0]);
		dly_r = signed'(dly_word[ENTRY_W-1:STORE_W]);
		pe_l  = dly_l * eg_q;
		pe_r  = dly_r * eg_q;
		pf_l  = dly_l * fg_q;
		pf_r  = dly_r * fg_q;
	end

	// stage 2: truncate, mix, saturate
	always_comb begin
		out_l      = sat16(mix(frame_s2.left_in, scale_q14(pe_l_s2)));
		out_r      = sat16(mix(frame_s2.right_in, scale_q14(pe_r_s2)));
		st_l       = sat16(mix(frame_s2.left_in, scale_q14(pf_l_s2)));
		st_r       = sat16(mix(frame_s2.right_in, scale_q14(pf_r_s2)));
		store_word = {st_r, st_l};
		if (wr_s2) begin
			result.left_out  = {{(SAMPLE_W-STORE_W){out_l[STORE_W-1]}}, out_l};
			result.right_out = {{(SAMPLE_W-STORE_W){out_r[STORE_W-1]}}, out_r};
		end else begin
			result.left_out  = frame_s2.left_in;
			result.right_out = frame_s2.right_in;
		end
		result.block_end_out = frame_s2.block_end;
	end

	sfe_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (v_s2),
		.push_word  (result),
		.word_valid (echo_valid),
		.word_stall (echo_stall),
		.word       (echo),
		.count      (oq_count)
	);

	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= (OQ_CNT_W+1)'(OQ_DEPTH))
		else $error("result queue overcommitted");

	a_wp_adv: assert property (@(posedge clk) disable iff (!arst_n)
		accept && enable_q |=> wp_q != $past(wp_q))
		else $error("write pointer did not advance");

	a_wp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && enable_q) |=> $stable(wp_q))
		else $error("write pointer moved without an echo frame");

	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= PTR_W'(RING_LENGTH - 1))
		else $error("write pointer beyond ring");

	a_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && wr_s1 && v_s2 && wr_s2 |-> wp_s1 != wp_s2)
		else $error("two in-flight writes to one entry");

endmodule
